FILE: design/rsd_pkg.sv
// shared types and constants for the ray-sphere distance pipeline
package rsd_pkg;

  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 32;

  localparam logic signed [34:0] DIST_MAX = 35'sd2147483647;
  localparam logic signed [34:0] DIST_MIN = -35'sd2147483648;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [62:0]        radius_sq;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] distance;
    logic               no_hit;
    logic               starts_outside;
    logic               saturated;
  } out_word_t;

  // per-item data that rides alongside the divider
  typedef struct packed {
    logic [63:0] x2;
    logic [62:0] r2;
    logic        zero_dir;
    logic        dneg;
    logic        outside;
  } div_side_t;

  // per-item data that rides alongside the square roots
  typedef struct packed {
    logic nohit;
    logic dneg;
    logic outside;
  } sq_side_t;

endpackage

FILE: design/ray_sphere_distance_core.sv
// top level: ray to centred sphere distance pipeline with output buffer
// Takes one word per cycle while in_ready is high and returns one result word per input
// word, in order. The pipeline has 5 front-end stages (products, sums, dot-product
// square), 64 divider stages (one quotient bit each), 3 clamp/discriminant stages,
// 32 square-root stages (one root bit each) and 2 stages forming and clamping the
// distance. A two-word output buffer lets the pipeline keep moving while a result
// waits; the whole pipeline holds only when that buffer is full.
module ray_sphere_distance_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rsd_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output rsd_pkg::out_word_t  out_word
);
  import rsd_pkg::*;

  logic         ce;
  logic         fv, dv, sv;
  logic [127:0] num;
  logic [63:0]  den, quo;
  div_side_t    fside, dside;
  sq_side_t     sside;
  logic [31:0]  root_q, root_arg;

  logic              va_r, vb_r, vc_r, vd_r, ve_r;
  logic [63:0]       qa_r, qb_r, qc_r, diff_r, arg_r;
  div_side_t         sa_r, sb_r;
  sq_side_t          sc_r, sd_r;
  logic signed [34:0] dist_r;
  logic signed [34:0] sval, rval;
  out_word_t         we_r, res;
  out_word_t         buf0_r, buf1_r;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              push, pop;

  assign ce       = (cnt_r != 2'd2) || out_ready;
  assign in_ready = ce;

  rsd_front u_front (
    .clk, .rst_n, .ce, .in_valid, .in_word,
    .out_valid(fv), .num, .den, .side(fside)
  );

  rsd_div u_div (
    .clk, .rst_n, .ce, .in_valid(fv), .num, .den, .side_in(fside),
    .out_valid(dv), .quo, .side_out(dside)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else if (ce) begin
      va_r <= dv;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= sv;
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      // s^2 can never exceed |X|^2 mathematically; the clamp guards the overflow code
      qa_r   <= (quo > dside.x2) ? dside.x2 : quo;
      sa_r   <= dside;
      qb_r   <= qa_r;
      diff_r <= sa_r.x2 - qa_r;
      sb_r   <= sa_r;
      qc_r   <= qb_r;
      arg_r  <= {1'b0, sb_r.r2} - diff_r;
      sc_r.nohit   <= sb_r.zero_dir || ({1'b0, sb_r.r2} < diff_r);
      sc_r.dneg    <= sb_r.dneg;
      sc_r.outside <= sb_r.outside;
    end
  end

  rsd_sqrt u_sqrt (
    .clk, .rst_n, .ce, .in_valid(vc_r), .rad_a(qc_r), .rad_b(arg_r), .side_in(sc_r),
    .out_valid(sv), .root_a(root_q), .root_b(root_arg), .side_out(sside)
  );

  assign sval = sside.dneg ? -35'(root_q) : 35'(root_q);
  assign rval = 35'(root_arg);

  always_comb begin
    res.no_hit         = sd_r.nohit;
    res.starts_outside = sd_r.outside;
    res.saturated      = 1'b0;
    res.distance       = '0;
    if (!sd_r.nohit) begin
      if (dist_r > DIST_MAX) begin
        res.distance  = DIST_MAX[31:0];
        res.saturated = 1'b1;
      end else if (dist_r < DIST_MIN) begin
        res.distance  = DIST_MIN[31:0];
        res.saturated = 1'b1;
      end else begin
        res.distance  = dist_r[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dist_r <= sside.outside ? (-sval - rval) : (-sval + rval);
      sd_r   <= sside;
      we_r   <= res;
    end
  end

  // two-word output buffer, head in buf0
  assign push    = ce && ve_r;
  assign pop     = out_valid && out_ready;
  assign cnt_nxt = 2'(cnt_r + {1'b0, push} - {1'b0, pop});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (cnt_r == 2'd2) begin
        buf0_r <= buf1_r;
        if (push) buf1_r <= we_r;
      end else if (push) begin
        buf0_r <= we_r;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) buf0_r <= we_r;
      else buf1_r <= we_r;
    end
  end

  assign out_valid = cnt_r != 2'd0;
  assign out_word  = buf0_r;

endmodule

FILE: design/rsd_front.sv
// front end: products, squared lengths, dot product and its 128-bit square
module rsd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ce,
  input  logic                in_valid,
  input  rsd_pkg::in_word_t   in_word,
  output logic                out_valid,
  output logic [127:0]        num,
  output logic [63:0]         den,
  output rsd_pkg::div_side_t  side
);
  import rsd_pkg::*;

  logic               v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [63:0] pxx_r, pyy_r, pzz_r, dxx_r, dyy_r, dzz_r, dpx_r, dpy_r, dpz_r;
  logic [62:0]        r2_1_r, r2_2_r, r2_3_r, r2_4_r, r2_5_r;
  logic [63:0]        x2_2_r, s2_2_r, x2_3_r, s2_3_r, x2_4_r, s2_4_r, x2_5_r, s2_5_r;
  logic signed [65:0] d2_r;
  logic [63:0]        dmag3_r;
  logic               dneg3_r, out3_r, zero3_r, dneg4_r, out4_r, zero4_r;
  logic               dneg5_r, out5_r, zero5_r;
  logic [63:0]        ll_r, lh_r, hh_r;
  logic [127:0]       num5_r;
  logic signed [65:0] dsum;

  assign dsum = 66'(dpx_r) + 66'(dpy_r) + 66'(dpz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pxx_r  <= 64'(in_word.pos_x) * 64'(in_word.pos_x);
      pyy_r  <= 64'(in_word.pos_y) * 64'(in_word.pos_y);
      pzz_r  <= 64'(in_word.pos_z) * 64'(in_word.pos_z);
      dxx_r  <= 64'(in_word.dir_x) * 64'(in_word.dir_x);
      dyy_r  <= 64'(in_word.dir_y) * 64'(in_word.dir_y);
      dzz_r  <= 64'(in_word.dir_z) * 64'(in_word.dir_z);
      dpx_r  <= 64'(in_word.pos_x) * 64'(in_word.dir_x);
      dpy_r  <= 64'(in_word.pos_y) * 64'(in_word.dir_y);
      dpz_r  <= 64'(in_word.pos_z) * 64'(in_word.dir_z);
      r2_1_r <= in_word.radius_sq;

      // squares are at most 2^62 each, so the sums fit in 64 bits
      x2_2_r <= 64'(pxx_r) + 64'(pyy_r) + 64'(pzz_r);
      s2_2_r <= 64'(dxx_r) + 64'(dyy_r) + 64'(dzz_r);
      d2_r   <= dsum;
      r2_2_r <= r2_1_r;

      dmag3_r <= d2_r[65] ? 64'(-d2_r) : d2_r[63:0];
      dneg3_r <= d2_r[65];
      out3_r  <= x2_2_r > {1'b0, r2_2_r};
      zero3_r <= s2_2_r == 64'd0;
      x2_3_r  <= x2_2_r;
      s2_3_r  <= s2_2_r;
      r2_3_r  <= r2_2_r;

      ll_r    <= 64'(dmag3_r[31:0]) * 64'(dmag3_r[31:0]);
      lh_r    <= 64'(dmag3_r[31:0]) * 64'(dmag3_r[63:32]);
      hh_r    <= 64'(dmag3_r[63:32]) * 64'(dmag3_r[63:32]);
      dneg4_r <= dneg3_r;
      out4_r  <= out3_r;
      zero4_r <= zero3_r;
      x2_4_r  <= x2_3_r;
      s2_4_r  <= s2_3_r;
      r2_4_r  <= r2_3_r;

      // cross term appears twice, hence the shift by 33
      num5_r  <= {hh_r, 64'd0} + {31'd0, lh_r, 33'd0} + {64'd0, ll_r};
      dneg5_r <= dneg4_r;
      out5_r  <= out4_r;
      zero5_r <= zero4_r;
      x2_5_r  <= x2_4_r;
      s2_5_r  <= s2_4_r;
      r2_5_r  <= r2_4_r;
    end
  end

  assign out_valid     = v5_r;
  assign num           = num5_r;
  assign den           = s2_5_r;
  assign side.x2       = x2_5_r;
  assign side.r2       = r2_5_r;
  assign side.zero_dir = zero5_r;
  assign side.dneg     = dneg5_r;
  assign side.outside  = out5_r;

endmodule

FILE: design/rsd_div.sv
// pipelined restoring divider, one quotient bit per stage
module rsd_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ce,
  input  logic                in_valid,
  input  logic [127:0]        num,
  input  logic [63:0]         den,
  input  rsd_pkg::div_side_t  side_in,
  output logic                out_valid,
  output logic [63:0]         quo,
  output rsd_pkg::div_side_t  side_out
);
  import rsd_pkg::*;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] low;
    logic [63:0] q;
    logic [63:0] d;
    logic        ovf;
    div_side_t   side;
  } div_st_t;

  div_st_t st0;
  div_st_t st_r [1:DIV_STEPS];
  logic    v_r  [1:DIV_STEPS];

  function automatic div_st_t div_step(div_st_t s);
    logic [64:0] t;
    div_st_t     o;
    t = {s.rem, s.low[63]};
    o = s;
    o.low = {s.low[62:0], 1'b0};
    if (t >= {1'b0, s.d}) begin
      o.rem = 64'(t - {1'b0, s.d});
      o.q   = {s.q[62:0], 1'b1};
    end else begin
      o.rem = t[63:0];
      o.q   = {s.q[62:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    st0.rem  = num[127:64];
    st0.low  = num[63:0];
    st0.q    = 64'd0;
    st0.d    = den;
    st0.ovf  = num[127:64] >= den;
    st0.side = side_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= DIV_STEPS; k++) v_r[k] <= 1'b0;
    end else if (ce) begin
      v_r[1] <= in_valid;
      for (int k = 2; k <= DIV_STEPS; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      st_r[1] <= div_step(st0);
      for (int k = 2; k <= DIV_STEPS; k++) st_r[k] <= div_step(st_r[k-1]);
    end
  end

  assign out_valid = v_r[DIV_STEPS];
  assign quo       = st_r[DIV_STEPS].ovf ? '1 : st_r[DIV_STEPS].q;
  assign side_out  = st_r[DIV_STEPS].side;

endmodule

FILE: design/rsd_sqrt.sv
// two-lane pipelined integer square root, one root bit per stage
module rsd_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ce,
  input  logic               in_valid,
  input  logic [63:0]        rad_a,
  input  logic [63:0]        rad_b,
  input  rsd_pkg::sq_side_t  side_in,
  output logic               out_valid,
  output logic [31:0]        root_a,
  output logic [31:0]        root_b,
  output rsd_pkg::sq_side_t  side_out
);
  import rsd_pkg::*;

  typedef struct packed {
    logic [63:0] v;
    logic [31:0] r;
    logic [33:0] m;
  } lane_t;

  lane_t    la0, lb0;
  lane_t    la_r [1:SQRT_STEPS];
  lane_t    lb_r [1:SQRT_STEPS];
  sq_side_t sd_r [1:SQRT_STEPS];
  logic     v_r  [1:SQRT_STEPS];

  function automatic lane_t sq_step(lane_t l);
    logic [35:0] t;
    logic [35:0] trial;
    lane_t       o;
    t     = {l.m, l.v[63:62]};
    trial = {2'b00, l.r, 2'b01};
    o.v   = {l.v[61:0], 2'b00};
    if (t >= trial) begin
      o.m = 34'(t - trial);
      o.r = {l.r[30:0], 1'b1};
    end else begin
      o.m = t[33:0];
      o.r = {l.r[30:0], 1'b0};
    end
    return o;
  endfunction

  assign la0 = '{v: rad_a, r: 32'd0, m: 34'd0};
  assign lb0 = '{v: rad_b, r: 32'd0, m: 34'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= SQRT_STEPS; k++) v_r[k] <= 1'b0;
    end else if (ce) begin
      v_r[1] <= in_valid;
      for (int k = 2; k <= SQRT_STEPS; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      la_r[1] <= sq_step(la0);
      lb_r[1] <= sq_step(lb0);
      sd_r[1] <= side_in;
      for (int k = 2; k <= SQRT_STEPS; k++) begin
        la_r[k] <= sq_step(la_r[k-1]);
        lb_r[k] <= sq_step(lb_r[k-1]);
        sd_r[k] <= sd_r[k-1];
      end
    end
  end

  assign out_valid = v_r[SQRT_STEPS];
  assign root_a    = la_r[SQRT_STEPS].r;
  assign root_b    = lb_r[SQRT_STEPS].r;
  assign side_out  = sd_r[SQRT_STEPS];

endmodule

FILE: design/rsd_checker.sv
// port-level checks for the ray-sphere distance core
module rsd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input rsd_pkg::out_word_t  out_word
);
  import rsd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_word))
    else $error("output word changed while stalled");

  a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.no_hit |-> out_word.distance == 32'sd0 && !out_word.saturated)
    else $error("miss carries a distance or saturation");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.saturated |->
      out_word.distance == DIST_MAX[31:0] || out_word.distance == DIST_MIN[31:0])
    else $error("saturated distance not at a range limit");

endmodule

bind ray_sphere_distance_core rsd_checker u_rsd_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_word
);

FILE: tb/testbench.sv
// self-checking testbench for the ray to centred sphere distance pipeline
module testbench;
  import rsd_pkg::*;

  localparam int LATENCY = 106;
  localparam int N_RANDOM = 800;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;

  out_word_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  ray_sphere_distance_core DUT (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_word(in_word), .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      b = r | (64'd1 << i);
      if (b * b <= v) r = b;
    end
    return r;
  endfunction

  // distance to the sphere surface along the direction
  function automatic out_word_t surface_distance(in_word_t w);
    out_word_t res;
    logic [63:0] s2, x2, pmag, dmag, q, diff, arg, root, sabs;
    logic [127:0] dsq;
    logic signed [65:0] dot, path_len;
    logic signed [63:0] s;
    s2 = 64'(64'(w.dir_x) * 64'(w.dir_x)) + 64'(64'(w.dir_y) * 64'(w.dir_y))
       + 64'(64'(w.dir_z) * 64'(w.dir_z));
    x2 = 64'(64'(w.pos_x) * 64'(w.pos_x)) + 64'(64'(w.pos_y) * 64'(w.pos_y))
       + 64'(64'(w.pos_z) * 64'(w.pos_z));
    res = '0;
    res.no_hit = 1'b1;
    res.starts_outside = x2 > {1'b0, w.radius_sq};
    if (s2 == 0) return res;
    dot = 66'(64'sd0 + w.pos_x * w.dir_x) + 66'(64'sd0 + w.pos_y * w.dir_y)
        + 66'(64'sd0 + w.pos_z * w.dir_z);
    dmag = dot < 0 ? 64'(-dot) : 64'(dot);
    dsq = 128'(dmag) * 128'(dmag);
    pmag = 64'(dsq / s2);
    if (dsq / s2 > 128'(x2)) q = x2;
    else q = pmag;
    diff = x2 - q;
    if ({1'b0, w.radius_sq} < diff) return res;
    arg = {1'b0, w.radius_sq} - diff;
    root = int_sqrt(arg);
    sabs = int_sqrt(q);
    s = dot < 0 ? -$signed(sabs) : $signed(sabs);
    path_len = res.starts_outside ? -66'(s) - 66'(root) : -66'(s) + 66'(root);
    res.no_hit = 1'b0;
    if (path_len > 66'sd2147483647) begin
      res.distance = 32'h7fffffff;
      res.saturated = 1'b1;
    end else if (path_len < -66'sd2147483648) begin
      res.distance = 32'h80000000;
      res.saturated = 1'b1;
    end else begin
      res.distance = path_len[31:0];
    end
    return res;
  endfunction

  typedef struct {
    in_word_t   w;
    bit         typed;
    out_word_t  res;
  } directed_row_t;

  directed_row_t rows[$];

  function automatic void add_row(in_word_t w, bit typed, out_word_t res);
    directed_row_t r;
    r.w = w;
    r.typed = typed;
    r.res = res;
    rows = {rows, r};
  endfunction

  function automatic in_word_t make_word(int px, int py, int pz, int dx, int dy, int dz,
                                         logic [62:0] r2);
    in_word_t w;
    w.pos_x = px; w.pos_y = py; w.pos_z = pz;
    w.dir_x = dx; w.dir_y = dy; w.dir_z = dz;
    w.radius_sq = r2;
    return w;
  endfunction

  function automatic out_word_t make_res(int d, bit nh, bit so, bit sat);
    out_word_t r;
    r.distance = d; r.no_hit = nh; r.starts_outside = so; r.saturated = sat;
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
      2: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      3: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return 32'(int'($urandom_range(0, 20)) - 10) <<< 16;
    endcase
  endfunction

  // mostly rays that meet a sphere of sensible size, plus some wild ones
  function automatic in_word_t rand_word();
    in_word_t w;
    logic [63:0] x2;
    w.pos_x = rand_coord(); w.pos_y = rand_coord(); w.pos_z = rand_coord();
    w.dir_x = rand_coord(); w.dir_y = rand_coord(); w.dir_z = rand_coord();
    if ($urandom_range(0, 19) == 0) begin
      w.dir_x = 0; w.dir_y = 0; w.dir_z = 0;
    end
    x2 = 64'(64'(w.pos_x) * 64'(w.pos_x)) + 64'(64'(w.pos_y) * 64'(w.pos_y))
       + 64'(64'(w.pos_z) * 64'(w.pos_z));
    case ($urandom_range(0, 4))
      0: w.radius_sq = 63'({$urandom(), $urandom()});
      1: w.radius_sq = x2[62:0];
      2: w.radius_sq = x2[62:0] + 63'($urandom_range(0, 1000));
      3: w.radius_sq = x2[62:0] - 63'($urandom_range(0, 1000));
      default: w.radius_sq = 63'(63'(x2 >> $urandom_range(0, 4))
                                 + ({$urandom(), $urandom()} % (x2 + 1)));
    endcase
    return w;
  endfunction

  task automatic send(in_word_t w, out_word_t res);
    while (!calm && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    expected_q = {expected_q, res};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (calm) out_ready <= 1'b1;
    else out_ready <= $urandom_range(0, 99) >= 14;
  end

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: %h", out_word);
        errors++;
      end else begin
        exp_w = expected_q.pop_front();
        if (out_word.distance !== exp_w.distance) begin
          $error("distance expected %0d actual %0d", exp_w.distance, out_word.distance);
          errors++;
        end
        if (out_word.no_hit !== exp_w.no_hit) begin
          $error("no_hit expected %0b actual %0b", exp_w.no_hit, out_word.no_hit);
          errors++;
        end
        if (out_word.starts_outside !== exp_w.starts_outside) begin
          $error("starts_outside expected %0b actual %0b", exp_w.starts_outside,
                 out_word.starts_outside);
          errors++;
        end
        if (out_word.saturated !== exp_w.saturated) begin
          $error("saturated expected %0b actual %0b", exp_w.saturated, out_word.saturated);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    in_word_t w;
    out_word_t res;
    int wait_cycles;
    // typed rows: zero direction, on surface, simple hits from inside and outside, a miss, saturation
    add_row(make_word(0, 0, 0, 0, 0, 0, 0), 1'b1, make_res(0, 1, 0, 0));
    add_row(make_word(32'h10000, 0, 0, 0, 0, 0, 0), 1'b1, make_res(0, 1, 1, 0));
    add_row(make_word(0, 0, 0, 32'h10000, 0, 0, 63'h1_0000_0000), 1'b1,
            make_res(32'h10000, 0, 0, 0));
    add_row(make_word(32'h20000, 0, 0, -32'sh10000, 0, 0, 63'h1_0000_0000), 1'b1,
            make_res(32'h10000, 0, 1, 0));
    add_row(make_word(32'h10000, 0, 0, 32'h10000, 0, 0, 63'h1_0000_0000), 1'b1,
            make_res(0, 0, 0, 0));
    add_row(make_word(32'h20000, 0, 0, 0, 32'h10000, 0, 63'h1_0000_0000), 1'b1,
            make_res(0, 1, 1, 0));
    add_row(make_word(0, 0, 0, 32'h10000, 0, 0, 63'h7fff_ffff_ffff_ffff), 1'b1,
            make_res(32'h7fff_ffff, 0, 0, 1));
    // extremes and small cases, checked by the predictor
    add_row(make_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 63'h7fff_ffff_ffff_ffff), 1'b0, '0);
    add_row(make_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0), 1'b0, '0);
    add_row(make_word(32'h8000_0000, 0, 0, 32'h7fff_ffff, 0, 0,
            63'h7fff_ffff_ffff_ffff), 1'b0, '0);
    add_row(make_word(32'h7fff_ffff, 0, 0, 32'h7fff_ffff, 0, 0,
            63'h7fff_ffff_ffff_ffff), 1'b0, '0);
    add_row(make_word(32'h8000_0000, 32'h8000_0000, 0, 1, -1, 0,
            63'h7fff_ffff_ffff_ffff), 1'b0, '0);
    add_row(make_word(1, -1, 1, -1, 1, -1, 3), 1'b0, '0);
    add_row(make_word(32'h30000, 32'h40000, 0, 1, 1, 1, 63'h19_0000_0000), 1'b0, '0);
    add_row(make_word(32'h30000, 32'h40000, 0, 0, 0, -7, 63'h18_ffff_ffff), 1'b0, '0);
    add_row(make_word(-5, 7, -9, 32'h8000_0000, 32'h7fff_ffff, 1,
            63'h5555_5555_5555_5555), 1'b0, '0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      res = rows[i].typed ? rows[i].res : surface_distance(rows[i].w);
      send(rows[i].w, res);
    end
    drop_valid();

    // hold off the sender until the pipeline has drained
    wait_cycles = 0;
    while (expected_q.size() != 0 && wait_cycles < STALL_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (n >= 300 && n < 420);
      w = rand_word();
      send(w, surface_distance(w));
    end
    drop_valid();
    calm = 1'b0;

    wait_cycles = 0;
    while (expected_q.size() != 0 && wait_cycles < STALL_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: ray_sphere_distance_core.f
design/rsd_pkg.sv
design/rsd_front.sv
design/rsd_div.sv
design/rsd_sqrt.sv
design/ray_sphere_distance_core.sv
design/rsd_checker.sv
tb/testbench.sv
